// ===== hdl/fctc_pkg.sv =====
// Shared types, character codes and byte helpers for the file content classifier.
package fctc_pkg;

    // Result class codes
    localparam logic [1:0] CLASS_TEXT   = 2'd0;
    localparam logic [1:0] CLASS_BINARY = 2'd1;
    localparam logic [1:0] CLASS_HTML   = 2'd2;
    localparam logic [1:0] CLASS_LATEX  = 2'd3;

    // Character codes
    localparam logic [7:0] CHR_LT     = 8'h3C;  // '<'
    localparam logic [7:0] CHR_GT     = 8'h3E;  // '>'
    localparam logic [7:0] CHR_SLASH  = 8'h2F;  // '/'
    localparam logic [7:0] CHR_BSL    = 8'h5C;  // '\'
    localparam logic [7:0] CHR_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CHR_LBRACE = 8'h7B;  // '{'
    localparam logic [7:0] CHR_A      = 8'h61;
    localparam logic [7:0] CHR_B      = 8'h62;
    localparam logic [7:0] CHR_D      = 8'h64;
    localparam logic [7:0] CHR_E      = 8'h65;
    localparam logic [7:0] CHR_G      = 8'h67;
    localparam logic [7:0] CHR_H      = 8'h68;
    localparam logic [7:0] CHR_I      = 8'h69;
    localparam logic [7:0] CHR_L      = 8'h6C;
    localparam logic [7:0] CHR_M      = 8'h6D;
    localparam logic [7:0] CHR_N      = 8'h6E;
    localparam logic [7:0] CHR_O      = 8'h6F;
    localparam logic [7:0] CHR_P      = 8'h70;
    localparam logic [7:0] CHR_T      = 8'h74;
    localparam logic [7:0] CHR_Y      = 8'h79;

    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Tag matcher states: partial "<body", "<html", "<img", "<p", "</a"
    typedef enum logic [4:0] {
        TG_IDLE,
        TG_LT,
        TG_B,
        TG_BO,
        TG_BOD,
        TG_BODY,
        TG_H,
        TG_HT,
        TG_HTM,
        TG_HTML,
        TG_I,
        TG_IM,
        TG_IMG,
        TG_P,
        TG_SLASH,
        TG_SLASH_A
    } tag_state_t;

    // Command matcher states: partial "\begin{" and "\end{"
    typedef enum logic [3:0] {
        LX_IDLE,
        LX_BSL,
        LX_B,
        LX_BE,
        LX_BEG,
        LX_BEGI,
        LX_BEGIN,
        LX_E,
        LX_EN,
        LX_END
    } latex_state_t;

    // Tag matcher status toward the flag logic
    typedef struct packed {
        logic hit;      // complete tag closed by this byte
        logic end_hit;  // body or html open when the file ends here
    } tag_status_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_binary(input logic [7:0] c);
        return c inside {[8'h00:8'h06], 8'h80, 8'h81};
    endfunction

endpackage

// ===== hdl/fctc_tag_matcher.sv =====
// Case-insensitive HTML tag matcher state machine.
module fctc_tag_matcher
    import fctc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic         clear,
    input  logic [7:0]   data,
    output tag_status_t  status
);

    tag_state_t state_reg;
    tag_state_t state_next;
    logic [7:0] lc;

    assign lc = to_lower(data);

    // Next state: a '<' that breaks a partial match restarts at once
    always_comb begin
        state_next = (data == CHR_LT) ? TG_LT : TG_IDLE;
        case (state_reg)
            TG_LT: begin
                if (lc == CHR_B) begin
                    state_next = TG_B;
                end else if (lc == CHR_H) begin
                    state_next = TG_H;
                end else if (lc == CHR_I) begin
                    state_next = TG_I;
                end else if (lc == CHR_P) begin
                    state_next = TG_P;
                end else if (lc == CHR_SLASH) begin
                    state_next = TG_SLASH;
                end
            end
            TG_B:     if (lc == CHR_O) state_next = TG_BO;
            TG_BO:    if (lc == CHR_D) state_next = TG_BOD;
            TG_BOD:   if (lc == CHR_Y) state_next = TG_BODY;
            TG_H:     if (lc == CHR_T) state_next = TG_HT;
            TG_HT:    if (lc == CHR_M) state_next = TG_HTM;
            TG_HTM:   if (lc == CHR_L) state_next = TG_HTML;
            TG_I:     if (lc == CHR_M) state_next = TG_IM;
            TG_IM:    if (lc == CHR_G) state_next = TG_IMG;
            TG_SLASH: if (lc == CHR_A) state_next = TG_SLASH_A;
            default: ;
        endcase
    end

    // Outputs: tag completed by this byte, or left open at end of file
    always_comb begin
        status.hit = 1'b0;
        case (state_reg)
            TG_BODY, TG_HTML:   status.hit = !is_alnum(data);
            TG_IMG:             status.hit = is_space(data);
            TG_P, TG_SLASH_A:   status.hit = (data == CHR_GT);
            default:            status.hit = 1'b0;
        endcase
        status.end_hit = (state_next == TG_BODY) || (state_next == TG_HTML);
    end

    // State register, back to idle after the last byte of a file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TG_IDLE;
        end else if (step) begin
            state_reg <= clear ? TG_IDLE : state_next;
        end
    end

endmodule

// ===== hdl/fctc_latex_matcher.sv =====
// Matcher for the "\begin{" and "\end{" commands.
module fctc_latex_matcher
    import fctc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        clear,
    input  logic [7:0]  data,
    output logic        hit
);

    latex_state_t state_reg;
    latex_state_t state_next;

    // Next state: a '\' that breaks a partial match restarts at once
    always_comb begin
        state_next = (data == CHR_BSL) ? LX_BSL : LX_IDLE;
        case (state_reg)
            LX_BSL: begin
                if (data == CHR_B) begin
                    state_next = LX_B;
                end else if (data == CHR_E) begin
                    state_next = LX_E;
                end
            end
            LX_B:    if (data == CHR_E) state_next = LX_BE;
            LX_BE:   if (data == CHR_G) state_next = LX_BEG;
            LX_BEG:  if (data == CHR_I) state_next = LX_BEGI;
            LX_BEGI: if (data == CHR_N) state_next = LX_BEGIN;
            LX_E:    if (data == CHR_N) state_next = LX_EN;
            LX_EN:   if (data == CHR_D) state_next = LX_END;
            default: ;
        endcase
    end

    // Output: command closed by a brace
    always_comb begin
        case (state_reg)
            LX_BEGIN, LX_END: hit = (data == CHR_LBRACE);
            default:          hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LX_IDLE;
        end else if (step) begin
            state_reg <= clear ? LX_IDLE : state_next;
        end
    end

endmodule

// ===== hdl/file_content_type_classifier_unit.sv =====
// Top level of the file content classifier: input register, matchers, flags, result register.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one file byte per transaction in
//   s_data_byte; s_last_byte marks the final byte of a file. Files follow one
//   another with no gap. Output channel (m_valid/m_ready) carries one
//   transaction per file in m_file_class: 0 text, 1 binary, 2 html, 3 latex.
//   Throughput: one byte per cycle, except that a last byte waits until the
//   result register is free; set by the update of the tag and command matchers
//   and the sticky flags between the input register and the result register.
//   The class is registered in the result register and presented on
//   m_file_class once the transaction carrying the last byte has passed the
//   input register, when the result register is free.
//   Reset (aresetn low, synchronous) empties both registers and returns all
//   matchers and flags to the start-of-file state.
//   When the receiver stalls, the result is held in the output register; bytes
//   that are not the last of a file keep flowing, and a last byte waits in the
//   input register until the output register is free.
module file_content_type_classifier_unit
    import fctc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_file_class
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic [1:0]  out_class_reg;
    logic [1:0]  out_class_next;

    logic        binary_found_reg;
    logic        html_found_reg;
    logic        latex_found_reg;
    logic        dollar_seen_reg;
    logic        bsl_seen_reg;
    logic        brace_seen_reg;

    logic        binary_found_next;
    logic        html_found_next;
    logic        latex_found_next;
    logic        dollar_seen_next;
    logic        bsl_seen_next;
    logic        brace_seen_next;

    logic        out_free;
    logic        proc_fire;
    tag_status_t tag_status;
    logic        latex_hit;

    // Handshake: a last byte needs room in the result register
    assign out_free  = !out_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready   = !in_valid_reg || proc_fire;

    assign m_valid      = out_valid_reg;
    assign m_file_class = out_class_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    fctc_tag_matcher u_tag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (proc_fire),
        .clear   (in_last_reg),
        .data    (in_byte_reg),
        .status  (tag_status)
    );

    fctc_latex_matcher u_latex (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (proc_fire),
        .clear   (in_last_reg),
        .data    (in_byte_reg),
        .hit     (latex_hit)
    );

    // Sticky flags including the current byte
    always_comb begin
        binary_found_next = binary_found_reg || is_binary(in_byte_reg);
        html_found_next   = html_found_reg || tag_status.hit;
        latex_found_next  = latex_found_reg || latex_hit;
        dollar_seen_next  = dollar_seen_reg || (in_byte_reg == CHR_DOLLAR);
        bsl_seen_next     = bsl_seen_reg || (in_byte_reg == CHR_BSL);
        brace_seen_next   = brace_seen_reg || (in_byte_reg == CHR_LBRACE);
    end

    // Class priority: binary, html, latex, text
    always_comb begin
        if (binary_found_next) begin
            out_class_next = CLASS_BINARY;
        end else if (html_found_next || tag_status.end_hit) begin
            out_class_next = CLASS_HTML;
        end else if (latex_found_next ||
                     (dollar_seen_next && bsl_seen_next && brace_seen_next)) begin
            out_class_next = CLASS_LATEX;
        end else begin
            out_class_next = CLASS_TEXT;
        end
    end

    // Flag registers, cleared after the last byte of a file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            binary_found_reg <= 1'b0;
            html_found_reg   <= 1'b0;
            latex_found_reg  <= 1'b0;
            dollar_seen_reg  <= 1'b0;
            bsl_seen_reg     <= 1'b0;
            brace_seen_reg   <= 1'b0;
        end else if (proc_fire) begin
            if (in_last_reg) begin
                binary_found_reg <= 1'b0;
                html_found_reg   <= 1'b0;
                latex_found_reg  <= 1'b0;
                dollar_seen_reg  <= 1'b0;
                bsl_seen_reg     <= 1'b0;
                brace_seen_reg   <= 1'b0;
            end else begin
                binary_found_reg <= binary_found_next;
                html_found_reg   <= html_found_next;
                latex_found_reg  <= latex_found_next;
                dollar_seen_reg  <= dollar_seen_next;
                bsl_seen_reg     <= bsl_seen_next;
                brace_seen_reg   <= brace_seen_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && in_last_reg) begin
            out_class_reg <= out_class_next;
        end
    end

endmodule
